FILE: rtl/czb_pkg.sv
// Package with the shared types, constants and shade tables of the cube point z-buffer shader.
`default_nettype none
package czb_pkg;

  localparam int CELL_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ONE_Q14 = 16384;
  localparam int D_OFFSET = 3 * ONE_Q14;
  localparam logic [7:0] BLANK_CHAR = 8'd32;
  localparam int SHADE_MAX = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SIN_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_B      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COL_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd7;

  localparam logic [2:0] FACE_ZP = 3'd0;
  localparam logic [2:0] FACE_ZN = 3'd1;
  localparam logic [2:0] FACE_XP = 3'd2;
  localparam logic [2:0] FACE_XN = 3'd3;
  localparam logic [2:0] FACE_YP = 3'd4;
  localparam logic [2:0] FACE_YN = 3'd5;

  localparam logic ACT_PLOT = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic               action;
    logic [2:0]         face;
    logic signed [15:0] coord_u;
    logic signed [15:0] coord_v;
    logic [CELL_W-1:0]  cell_index;
  } in_t;

  typedef struct packed {
    logic              drawn;
    logic [CELL_W-1:0] cell_out;
    logic [7:0]        cell_char;
  } out_t;

  // Threshold 2*k*k*2^28 that 121*L*L must reach for shade k.
  function automatic logic [52:0] shade_thr(input int k);
    logic [52:0] t;
    t = 53'(k * k);
    return t << 29;
  endfunction

  function automatic logic [7:0] shade_char(input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = 8'h2E;
      4'd1:    c = 8'h2C;
      4'd2:    c = 8'h2D;
      4'd3:    c = 8'h7E;
      4'd4:    c = 8'h3A;
      4'd5:    c = 8'h3B;
      4'd6:    c = 8'h3D;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h2A;
      4'd9:    c = 8'h23;
      4'd10:   c = 8'h24;
      4'd11:   c = 8'h40;
      default: c = BLANK_CHAR;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/czb_mem.sv
// Depth and shade cell memory with one write port and one registered read port.
`default_nettype none
module czb_mem #(
  parameter int DEPTH = 1760,
  parameter int AW = 11,
  parameter int DW = 20
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/czb_div.sv
// Bit-serial restoring divider that forms min(65535, 2^30 / divisor).
`default_nettype none
module czb_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [19:0] divisor,
  output logic             done,
  output logic [15:0]      quot
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [19:0] rem_r;
  logic [19:0] den_r;
  logic [30:0] q_r;
  logic [20:0] trial;

  assign trial = {rem_r, cnt_r == 5'd30};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd30;
        rem_r  <= '0;
        q_r    <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= 20'(trial - {1'b0, den_r});
          q_r   <= {q_r[29:0], 1'b1};
        end else begin
          rem_r <= trial[19:0];
          q_r   <= {q_r[29:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = (|q_r[30:16]) ? 16'hFFFF : q_r[15:0];

endmodule
`default_nettype wire

FILE: rtl/cube_point_zbuffer_shader.sv
// Top level of the cube point z-buffer shader: rotation, projection, shading and cell memory.
// One transaction is handled at a time. A plot that reaches the cell memory passes, between
// its acceptance and the next possible acceptance, through the accepting cycle, the seven
// rotation and projection steps, the bit-serial reciprocal of the depth, and the read and
// write back of the cell memory. A read and clear passes through the read and write back
// only. A result waits in the output register while the next transaction is accepted, and
// the write back is held while an earlier result still waits for out_ready. After reset the
// cell memory is cleared one cell per cycle, all COLS*ROWS cells, while in_ready stays low.
`default_nettype none
module cube_point_zbuffer_shader
  import czb_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 22
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NCELLS = COLS * ROWS;
  localparam int AW = $clog2(NCELLS);
  localparam int DW = 20;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_S1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_S2   = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_P1   = 4'd6;
  localparam logic [3:0] S_P2   = 4'd7;
  localparam logic [3:0] S_P3   = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_WB   = 4'd10;

  logic [3:0] state_r, state_nxt;

  logic signed [15:0] sin_a_r, cos_a_r, sin_b_r, cos_b_r;
  logic [7:0] col_scale_r, row_scale_r, center_col_r, center_row_r;

  logic clr_r;
  logic [AW-1:0] clr_cnt_r;

  logic is_rd_r, hit_r;
  logic [CELL_W-1:0] cell_r;
  logic [AW-1:0] addr_r;
  logic signed [16:0] px_r, py_r, pz_r, nx_r, ny_r, nz_r;
  logic signed [32:0] m1_r [8];
  logic signed [19:0] y1_r, z1_r, ny1_r, nz1_r;
  logic signed [36:0] m2_r [8];
  logic signed [20:0] d_r;
  logic signed [23:0] xx_r, yy_r;
  logic signed [24:0] l_r;
  logic [15:0] ooz_r;
  logic [45:0] sq_r;
  logic [52:0] lhs_r;
  logic signed [40:0] xo_r, yo_r;
  logic signed [49:0] xs_r, ys_r;
  logic [3:0] k_r;

  logic div_start, div_done;
  logic [15:0] div_quot;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  out_t out_r;
  logic out_valid_r;
  logic emit;

  logic signed [33:0] s1 [4];
  logic signed [37:0] s2 [4];
  logic signed [51:0] cnum, rnum;
  logic signed [21:0] col_w, row_w;
  logic [22:0] lmag;
  logic [3:0] k_w;

  always_comb begin
    s1[0] = 34'(m1_r[0]) - 34'(m1_r[1]);
    s1[1] = 34'(m1_r[2]) + 34'(m1_r[3]);
    s1[2] = 34'(m1_r[4]) - 34'(m1_r[5]);
    s1[3] = 34'(m1_r[6]) + 34'(m1_r[7]);
    s2[0] = 38'(m2_r[0]) - 38'(m2_r[1]);
    s2[1] = 38'(m2_r[2]) + 38'(m2_r[3]);
    s2[2] = 38'(m2_r[4]) - 38'(m2_r[5]);
    s2[3] = 38'(m2_r[6]) + 38'(m2_r[7]);
    cnum = (52'($signed({1'b0, center_col_r})) <<< 30) + 52'(xs_r);
    rnum = (52'($signed({1'b0, center_row_r})) <<< 30) + 52'(ys_r);
    if (cnum < 0) begin
      cnum = cnum + 52'sd1073741823;
    end
    if (rnum < 0) begin
      rnum = rnum + 52'sd1073741823;
    end
    col_w = cnum[51:30];
    row_w = rnum[51:30];
    lmag = (l_r > 0) ? l_r[22:0] : '0;
    k_w = '0;
    for (int k = 1; k <= SHADE_MAX; k++) begin
      k_w = k_w + 4'(lhs_r >= shade_thr(k));
    end
  end

  assign in_ready = (state_r == S_IDLE) && !clr_r;
  assign emit = (state_r == S_WB) && (!out_valid_r || out_ready);
  assign div_start = (state_r == S_S2) && (d_r > 0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.action == ACT_READ) begin
            state_nxt = (32'(in_data.cell_index) < NCELLS) ? S_RD : S_WB;
          end else if (in_data.face > FACE_YN) begin
            state_nxt = S_WB;
          end else begin
            state_nxt = S_M1;
          end
        end
      end
      S_M1:  state_nxt = S_S1;
      S_S1:  state_nxt = S_M2;
      S_M2:  state_nxt = S_S2;
      S_S2:  state_nxt = (d_r > 0) ? S_DIV : S_WB;
      S_DIV: state_nxt = div_done ? S_P1 : S_DIV;
      S_P1:  state_nxt = S_P2;
      S_P2:  state_nxt = S_P3;
      S_P3: begin
        if (col_w < 0 || col_w >= 22'(COLS) || row_w < 0 || row_w >= 22'(ROWS)) begin
          state_nxt = S_WB;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_WB;
      S_WB:  state_nxt = emit ? S_IDLE : S_WB;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sin_a_r      <= '0;
      cos_a_r      <= 16'sd16384;
      sin_b_r      <= '0;
      cos_b_r      <= 16'sd16384;
      col_scale_r  <= 8'd30;
      row_scale_r  <= 8'd15;
      center_col_r <= 8'd40;
      center_row_r <= 8'd12;
      clr_r        <= 1'b1;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      hit_r        <= 1'b0;
      is_rd_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(NCELLS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SIN_A:      sin_a_r      <= cfg_data;
          REG_COS_A:      cos_a_r      <= cfg_data;
          REG_SIN_B:      sin_b_r      <= cfg_data;
          REG_COS_B:      cos_b_r      <= cfg_data;
          REG_COL_SCALE:  col_scale_r  <= cfg_data[7:0];
          REG_ROW_SCALE:  row_scale_r  <= cfg_data[7:0];
          REG_CENTER_COL: center_col_r <= cfg_data[7:0];
          REG_CENTER_ROW: center_row_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            is_rd_r <= in_data.action;
            cell_r  <= in_data.cell_index;
            addr_r  <= AW'(in_data.cell_index);
            hit_r   <= (in_data.action == ACT_READ) &&
                       (32'(in_data.cell_index) < NCELLS);
            nx_r <= '0;
            ny_r <= '0;
            nz_r <= '0;
            case (in_data.face)
              FACE_ZP: begin
                px_r <= 17'(in_data.coord_u); py_r <= 17'(in_data.coord_v);
                pz_r <= 17'sd16384; nz_r <= 17'sd16384;
              end
              FACE_ZN: begin
                px_r <= 17'(in_data.coord_u); py_r <= 17'(in_data.coord_v);
                pz_r <= -17'sd16384; nz_r <= -17'sd16384;
              end
              FACE_XP: begin
                px_r <= 17'sd16384; py_r <= 17'(in_data.coord_u);
                pz_r <= 17'(in_data.coord_v); nx_r <= 17'sd16384;
              end
              FACE_XN: begin
                px_r <= -17'sd16384; py_r <= 17'(in_data.coord_u);
                pz_r <= 17'(in_data.coord_v); nx_r <= -17'sd16384;
              end
              FACE_YP: begin
                px_r <= 17'(in_data.coord_u); py_r <= 17'sd16384;
                pz_r <= 17'(in_data.coord_v); ny_r <= 17'sd16384;
              end
              default: begin
                px_r <= 17'(in_data.coord_u); py_r <= -17'sd16384;
                pz_r <= 17'(in_data.coord_v); ny_r <= -17'sd16384;
              end
            endcase
          end
        end
        S_M1: begin
          m1_r[0] <= py_r * cos_a_r;
          m1_r[1] <= pz_r * sin_a_r;
          m1_r[2] <= py_r * sin_a_r;
          m1_r[3] <= pz_r * cos_a_r;
          m1_r[4] <= ny_r * cos_a_r;
          m1_r[5] <= nz_r * sin_a_r;
          m1_r[6] <= ny_r * sin_a_r;
          m1_r[7] <= nz_r * cos_a_r;
        end
        S_S1: begin
          y1_r  <= s1[0][33:14];
          z1_r  <= s1[1][33:14];
          ny1_r <= s1[2][33:14];
          nz1_r <= s1[3][33:14];
        end
        S_M2: begin
          m2_r[0] <= px_r * cos_b_r;
          m2_r[1] <= y1_r * sin_b_r;
          m2_r[2] <= px_r * sin_b_r;
          m2_r[3] <= y1_r * cos_b_r;
          m2_r[4] <= nx_r * cos_b_r;
          m2_r[5] <= ny1_r * sin_b_r;
          m2_r[6] <= nx_r * sin_b_r;
          m2_r[7] <= ny1_r * cos_b_r;
          d_r     <= 21'(z1_r) + 21'sd49152;
        end
        S_S2: begin
          xx_r <= s2[0][37:14];
          yy_r <= s2[1][37:14];
          l_r  <= 25'($signed(s2[3][37:14])) - 25'(nz1_r);
        end
        S_DIV: begin
          sq_r <= lmag * lmag;
          if (div_done) begin
            ooz_r <= div_quot;
          end
        end
        S_P1: begin
          xo_r  <= xx_r * $signed({1'b0, ooz_r});
          yo_r  <= yy_r * $signed({1'b0, ooz_r});
          lhs_r <= (53'(sq_r) << 7) - (53'(sq_r) << 3) + 53'(sq_r);
        end
        S_P2: begin
          xs_r <= xo_r * $signed({1'b0, col_scale_r});
          ys_r <= yo_r * $signed({1'b0, row_scale_r});
          k_r  <= k_w;
        end
        S_P3: begin
          hit_r  <= !(col_w < 0 || col_w >= 22'(COLS) || row_w < 0 || row_w >= 22'(ROWS));
          addr_r <= AW'(32'(row_w[8:0]) * COLS + 32'(col_w[8:0]));
        end
        default: ;
      endcase
      if (emit) begin
        if (hit_r && is_rd_r) begin
          out_r.drawn     <= 1'b0;
          out_r.cell_out  <= cell_r;
          out_r.cell_char <= (mem_rdata[3:0] != 4'd0) ?
                             shade_char(mem_rdata[3:0] - 4'd1) : BLANK_CHAR;
        end else if (hit_r && (ooz_r > mem_rdata[19:4])) begin
          out_r.drawn     <= 1'b1;
          out_r.cell_out  <= CELL_W'(addr_r);
          out_r.cell_char <= shade_char(k_r);
        end else begin
          out_r.drawn     <= 1'b0;
          out_r.cell_out  <= is_rd_r ? cell_r : '0;
          out_r.cell_char <= BLANK_CHAR;
        end
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    if (clr_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
    end else if (emit && hit_r) begin
      if (is_rd_r) begin
        mem_we = 1'b1;
      end else if (ooz_r > mem_rdata[19:4]) begin
        mem_we    = 1'b1;
        mem_wdata = {ooz_r, k_r + 4'd1};
      end
    end
  end

  czb_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (d_r[19:0]),
    .done    (div_done),
    .quot    (div_quot)
  );

  czb_mem #(
    .DEPTH (NCELLS),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready)
    else $error("input accepted during memory clear");

  a_write_only_at_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && !clr_r) |-> (state_r == S_WB))
    else $error("cell memory written outside write back");

  a_drawn_has_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.drawn) |-> (out_data.cell_char != BLANK_CHAR))
    else $error("drawn result carries blank character");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

endmodule
`default_nettype wire
